[hdl/lru_tile_cache_core_macros.svh]
// assertion macros for the lru tile cache core checker
// no dependencies; included by the checker file
`ifndef LRU_TILE_CACHE_CORE_MACROS_SVH
`define LRU_TILE_CACHE_CORE_MACROS_SVH

// same-cycle implication, sampled on the rising clock edge
`define LRUTC_ASSERT_NOW(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("lru tile cache check failed");

// next-cycle implication
`define LRUTC_ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("lru tile cache check failed");

`endif

[hdl/lrutc_pkg.sv]
// shared types and constants for the lru tile cache
// no dependencies; used by every module of the block
`default_nettype none

package lrutc_pkg;

  // field widths
  localparam int TILE_W    = 24;
  localparam int ZOOM_W    = 5;
  localparam int OUTCOME_W = 2;
  localparam int STATUS_W  = 3;
  localparam int SLOT_W    = 4;
  localparam int STAMP_W   = 32;
  localparam int COUNT_W   = 32;

  localparam int CAPACITY_DEFAULT = 16;

  // zoom used when the register holds zero, and the register's reset value
  localparam logic [ZOOM_W-1:0] ZOOM_DEFAULT = 5'd11;

  // configuration port
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic REG_ZOOM = 1'b0;

  // fetch outcome codes
  localparam logic [OUTCOME_W-1:0] OUT_PENDING = 2'd0;
  localparam logic [OUTCOME_W-1:0] OUT_DATA    = 2'd1;
  localparam logic [OUTCOME_W-1:0] OUT_FAILED  = 2'd2;

  // lookup status codes
  localparam logic [STATUS_W-1:0] RES_HIT_DATA  = 3'd0;
  localparam logic [STATUS_W-1:0] RES_HIT_HOLE  = 3'd1;
  localparam logic [STATUS_W-1:0] RES_PENDING   = 3'd2;
  localparam logic [STATUS_W-1:0] RES_FILL_DATA = 3'd3;
  localparam logic [STATUS_W-1:0] RES_FILL_HOLE = 3'd4;

  // controller to datapath commands
  typedef struct packed {
    logic capture;  // latch the request
    logic match;    // register tag compare, load stamp tree
    logic step;     // reduce the stamp tree by one level
    logic commit;   // update entries and counters, emit the result
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic want_search;  // miss that must evict from a full store
  } status_t;

endpackage

`default_nettype wire

[hdl/lrutc_cfg.sv]
// zoom level register behind the apb-style configuration port
// depends on lrutc_pkg
`default_nettype none

module lrutc_cfg (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [lrutc_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [lrutc_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [lrutc_pkg::APB_DATA_W-1:0] prdata,
  output logic                                  pready,
  output logic      [lrutc_pkg::ZOOM_W-1:0]     zoom_level
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // register write
  always_ff @(posedge clk) begin
    if (rst) begin
      zoom_level <= lrutc_pkg::ZOOM_DEFAULT;
    end else if (wr_en) begin
      unique case (paddr[2])
        lrutc_pkg::REG_ZOOM: zoom_level <= pwdata[lrutc_pkg::ZOOM_W-1:0];
        default: ;
      endcase
    end
  end

  // register read
  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      lrutc_pkg::REG_ZOOM: prdata[lrutc_pkg::ZOOM_W-1:0] = zoom_level;
      default: prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

[hdl/lrutc_ctrl.sv]
// lookup sequencer: capture, match, optional lru search, commit
// depends on lrutc_pkg
`default_nettype none

module lrutc_ctrl #(
  parameter int CAPACITY = lrutc_pkg::CAPACITY_DEFAULT
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  output lrutc_pkg::cmd_t         cmd,
  input  wire lrutc_pkg::status_t status
);

  localparam int LEVELS = $clog2(CAPACITY);
  localparam int LVLW   = (LEVELS > 1) ? $clog2(LEVELS) : 1;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_MATCH  = 4'b0010,
    ST_SEARCH = 4'b0100,
    ST_WRITE  = 4'b1000
  } state_t;

  state_t          state, state_next;
  logic [LVLW-1:0] level, level_next;

  assign busy = (state != ST_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    level_next = level;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_next  = ST_MATCH;
        end
      end
      ST_MATCH: begin
        cmd.match  = 1'b1;
        level_next = '0;
        state_next = status.want_search ? ST_SEARCH : ST_WRITE;
      end
      ST_SEARCH: begin
        cmd.step = 1'b1;
        if (level == LVLW'(LEVELS - 1)) begin
          state_next = ST_WRITE;
        end else begin
          level_next = level + LVLW'(1);
        end
      end
      ST_WRITE: begin
        cmd.commit = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      level <= '0;
    end else begin
      state <= state_next;
      level <= level_next;
    end
  end

endmodule

`default_nettype wire

[hdl/lrutc_datapath.sv]
// entry store, tag compare, min-stamp tree, counters and result registers
// depends on lrutc_pkg
`default_nettype none

module lrutc_datapath #(
  parameter int CAPACITY = lrutc_pkg::CAPACITY_DEFAULT
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire lrutc_pkg::cmd_t                 cmd,
  output lrutc_pkg::status_t                   status,
  input  wire logic [lrutc_pkg::TILE_W-1:0]    tile_x,
  input  wire logic [lrutc_pkg::TILE_W-1:0]    tile_y,
  input  wire logic [lrutc_pkg::OUTCOME_W-1:0] fetch_outcome,
  input  wire logic [lrutc_pkg::ZOOM_W-1:0]    zoom_level,
  output logic                                 done,
  output logic      [lrutc_pkg::STATUS_W-1:0]  lookup_status,
  output logic      [lrutc_pkg::SLOT_W-1:0]    slot_index,
  output logic                                 evicted,
  output logic      [lrutc_pkg::COUNT_W-1:0]   fill_count
);

  localparam int IDXW   = $clog2(CAPACITY);
  localparam int CNTW   = $clog2(CAPACITY + 1);
  localparam int TREE_N = 1 << IDXW;

  // request registers
  logic [lrutc_pkg::TILE_W-1:0]    req_x, req_y;
  logic [lrutc_pkg::OUTCOME_W-1:0] req_outcome;
  logic [lrutc_pkg::ZOOM_W-1:0]    req_zoom;

  // entry store
  logic [lrutc_pkg::TILE_W-1:0]  entry_x     [CAPACITY];
  logic [lrutc_pkg::TILE_W-1:0]  entry_y     [CAPACITY];
  logic [lrutc_pkg::ZOOM_W-1:0]  entry_zoom  [CAPACITY];
  logic [lrutc_pkg::STAMP_W-1:0] entry_stamp [CAPACITY];
  logic [CAPACITY-1:0]           entry_has_data;

  // counters
  logic [CNTW-1:0]               used;
  logic [lrutc_pkg::STAMP_W-1:0] use_clock, use_clock_next;
  logic [lrutc_pkg::COUNT_W-1:0] data_fills, data_fills_next;

  // match results
  logic [CAPACITY-1:0] match;
  logic                hit_any, hit_data;
  logic [IDXW-1:0]     hit_idx;
  logic                hit_q, hit_data_q;
  logic [IDXW-1:0]     hit_idx_q;

  // min-stamp tree
  logic [lrutc_pkg::STAMP_W-1:0] leaf_stamp [TREE_N];
  logic                          leaf_vld   [TREE_N];
  logic [lrutc_pkg::STAMP_W-1:0] tree_stamp [TREE_N];
  logic [IDXW-1:0]               tree_idx   [TREE_N];
  logic                          tree_vld   [TREE_N];

  // commit decode
  logic            full, got, wr_en, stamp_en;
  logic [IDXW-1:0] wr_slot, stamp_slot, rep_slot;
  logic [IDXW+3:0] slot_ext;
  logic [lrutc_pkg::STATUS_W-1:0] res_code;

  // request capture with zoom substitution
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_x       <= tile_x;
      req_y       <= tile_y;
      req_outcome <= fetch_outcome;
      req_zoom    <= (zoom_level == '0) ? lrutc_pkg::ZOOM_DEFAULT : zoom_level;
    end
  end

  // parallel tag compare over occupied slots
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      match[i] = (CNTW'(i) < used) && (entry_zoom[i] == req_zoom) &&
                 (entry_x[i] == req_x) && (entry_y[i] == req_y);
    end
  end

  assign hit_any  = |match;
  assign hit_data = |(match & entry_has_data);

  // lowest matching slot
  always_comb begin
    hit_idx = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (match[i]) hit_idx = IDXW'(i);
    end
  end

  assign full   = (used == CNTW'(CAPACITY));
  assign status.want_search = !hit_any && (req_outcome != lrutc_pkg::OUT_PENDING) && full;

  // registered match outcome
  always_ff @(posedge clk) begin
    if (cmd.match) begin
      hit_q      <= hit_any;
      hit_data_q <= hit_data;
      hit_idx_q  <= hit_idx;
    end
  end

  // tree leaves: real slots are valid, padding leaves are not
  for (genvar g = 0; g < TREE_N; g++) begin : g_leaf
    if (g < CAPACITY) begin : g_slot
      assign leaf_stamp[g] = entry_stamp[g];
      assign leaf_vld[g]   = 1'b1;
    end else begin : g_pad
      assign leaf_stamp[g] = '0;
      assign leaf_vld[g]   = 1'b0;
    end
  end

  // min-stamp tree: loaded at match, one level per step, lowest index wins ties
  for (genvar g = 0; g < TREE_N; g++) begin : g_tree
    if (g < TREE_N / 2) begin : g_node
      always_ff @(posedge clk) begin
        if (cmd.match) begin
          tree_stamp[g] <= leaf_stamp[g];
          tree_idx[g]   <= IDXW'(g);
          tree_vld[g]   <= leaf_vld[g];
        end else if (cmd.step) begin
          if (tree_vld[2*g+1] &&
              (!tree_vld[2*g] || (tree_stamp[2*g+1] < tree_stamp[2*g]))) begin
            tree_stamp[g] <= tree_stamp[2*g+1];
            tree_idx[g]   <= tree_idx[2*g+1];
          end else begin
            tree_stamp[g] <= tree_stamp[2*g];
            tree_idx[g]   <= tree_idx[2*g];
          end
          tree_vld[g] <= tree_vld[2*g] | tree_vld[2*g+1];
        end
      end
    end else begin : g_upper
      always_ff @(posedge clk) begin
        if (cmd.match) begin
          tree_stamp[g] <= leaf_stamp[g];
          tree_idx[g]   <= IDXW'(g);
          tree_vld[g]   <= leaf_vld[g];
        end else if (cmd.step) begin
          tree_vld[g] <= 1'b0;
        end
      end
    end
  end

  // commit decode
  assign got        = (req_outcome == lrutc_pkg::OUT_DATA);
  assign wr_en      = cmd.commit && !hit_q && (req_outcome != lrutc_pkg::OUT_PENDING);
  assign stamp_en   = cmd.commit && (hit_q || wr_en);
  assign wr_slot    = full ? tree_idx[0] : used[IDXW-1:0];
  assign stamp_slot = hit_q ? hit_idx_q : wr_slot;
  assign rep_slot   = hit_q ? hit_idx_q : (wr_en ? wr_slot : '0);
  assign slot_ext   = {4'b0000, rep_slot};

  assign use_clock_next  = use_clock + lrutc_pkg::STAMP_W'(1);
  assign data_fills_next = data_fills + {{(lrutc_pkg::COUNT_W-1){1'b0}}, (wr_en && got)};

  always_comb begin
    if (hit_q) begin
      res_code = hit_data_q ? lrutc_pkg::RES_HIT_DATA : lrutc_pkg::RES_HIT_HOLE;
    end else if (!wr_en) begin
      res_code = lrutc_pkg::RES_PENDING;
    end else begin
      res_code = got ? lrutc_pkg::RES_FILL_DATA : lrutc_pkg::RES_FILL_HOLE;
    end
  end

  // entry writes
  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_x[wr_slot]        <= req_x;
      entry_y[wr_slot]        <= req_y;
      entry_zoom[wr_slot]     <= req_zoom;
      entry_has_data[wr_slot] <= got;
    end
    if (stamp_en) begin
      entry_stamp[stamp_slot] <= use_clock_next;
    end
  end

  // occupancy, stamp clock, fill count and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      used       <= '0;
      use_clock  <= '0;
      data_fills <= '0;
      done       <= 1'b0;
    end else begin
      done <= cmd.commit;
      if (wr_en && !full) used <= used + CNTW'(1);
      if (stamp_en) use_clock <= use_clock_next;
      if (cmd.commit) data_fills <= data_fills_next;
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      lookup_status <= res_code;
      slot_index    <= slot_ext[3:0];
      evicted       <= wr_en && full;
      fill_count    <= data_fills_next;
    end
  end

endmodule

`default_nettype wire

[hdl/lru_tile_cache_core.sv]
// top level of the lru tile cache: config register, sequencer, datapath
// depends on lrutc_pkg, lrutc_cfg, lrutc_ctrl, lrutc_datapath
//
// A fully associative tile cache with lru replacement and negative caching.
// Request channel: an item (tile_x, tile_y, fetch_outcome) is taken at a
// rising edge where start is high and busy is low. Tags are (zoom, x, y),
// with the zoom taken from the zoom_level register (zero reads as 11).
// Result channel: done is high for exactly one cycle with lookup_status,
// slot_index, evicted and fill_count; the receiver cannot stall it.
// Sequence: a hit, a pending miss or a fill into a free slot passes the match and
// write states after the accepting edge; done comes as busy falls, so a new item
// can be taken while done is high. A fill into a full store also passes the search
// state, where the registered min-stamp tree is reduced one level per cycle.
// The tag compare over all slots is combinational and registered in the match state.
// Reset: all slots empty, stamp clock and fill count zero, zoom_level 11.
// Configuration: apb-style, zoom_level at byte address 0, pready always high;
// the user must write it only while the block is idle; the block does not enforce this.
`default_nettype none

module lru_tile_cache_core #(
  parameter int CAPACITY = lrutc_pkg::CAPACITY_DEFAULT
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [lrutc_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [lrutc_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [lrutc_pkg::APB_DATA_W-1:0] prdata,
  output logic                                  pready,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic [lrutc_pkg::TILE_W-1:0]     tile_x,
  input  wire logic [lrutc_pkg::TILE_W-1:0]     tile_y,
  input  wire logic [lrutc_pkg::OUTCOME_W-1:0]  fetch_outcome,
  output logic                                  done,
  output logic      [lrutc_pkg::STATUS_W-1:0]   lookup_status,
  output logic      [lrutc_pkg::SLOT_W-1:0]     slot_index,
  output logic                                  evicted,
  output logic      [lrutc_pkg::COUNT_W-1:0]    fill_count
);

  logic [lrutc_pkg::ZOOM_W-1:0] zoom_level;
  lrutc_pkg::cmd_t              cmd;
  lrutc_pkg::status_t           status;

  // configuration register
  lrutc_cfg u_cfg (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .zoom_level (zoom_level)
  );

  // sequencer
  lrutc_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .status (status)
  );

  // datapath
  lrutc_datapath #(.CAPACITY(CAPACITY)) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .tile_x        (tile_x),
    .tile_y        (tile_y),
    .fetch_outcome (fetch_outcome),
    .zoom_level    (zoom_level),
    .done          (done),
    .lookup_status (lookup_status),
    .slot_index    (slot_index),
    .evicted       (evicted),
    .fill_count    (fill_count)
  );

endmodule

`default_nettype wire

[hdl/lrutc_checker.sv]
// port-level checks for the lru tile cache, bound to the top level
// depends on lrutc_pkg and lru_tile_cache_core_macros.svh
`default_nettype none
`include "lru_tile_cache_core_macros.svh"

module lrutc_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            start,
  input wire logic                            busy,
  input wire logic                            done,
  input wire logic [lrutc_pkg::STATUS_W-1:0]  lookup_status,
  input wire logic [lrutc_pkg::SLOT_W-1:0]    slot_index,
  input wire logic                            evicted
);

  // an accepted item holds the block busy in the next cycle
  `LRUTC_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy)

  // the result strobe lasts one cycle and the block is free again with it
  `LRUTC_ASSERT_NEXT(a_done_pulse, clk, rst, done, !done)
  `LRUTC_ASSERT_NOW(a_done_idle, clk, rst, done, !busy)

  // a pending miss reports slot zero and no eviction
  `LRUTC_ASSERT_NOW(a_pending_fields, clk, rst,
    done && (lookup_status == lrutc_pkg::RES_PENDING), (slot_index == '0) && !evicted)

  // a hit never evicts
  `LRUTC_ASSERT_NOW(a_hit_no_evict, clk, rst,
    done && ((lookup_status == lrutc_pkg::RES_HIT_DATA) ||
             (lookup_status == lrutc_pkg::RES_HIT_HOLE)), !evicted)

endmodule

bind lru_tile_cache_core lrutc_checker u_lrutc_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .done          (done),
  .lookup_status (lookup_status),
  .slot_index    (slot_index),
  .evicted       (evicted)
);

`default_nettype wire

[bench/tb.sv]
// self-checking bench for the lru tile cache core: lookups, fills, evictions, zoom tags
// depends on lrutc_pkg and lru_tile_cache_core; holds its own cache predictor
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lrutc_pkg::*;

  localparam int CAPACITY    = CAPACITY_DEFAULT;
  localparam int POOL_SIZE   = 32;
  localparam int PHASE_ITEMS = 200;
  localparam int CYCLE_LIMIT = 400000;

  // one request item and one lookup result
  typedef struct packed {
    logic [TILE_W-1:0]    x;
    logic [TILE_W-1:0]    y;
    logic [OUTCOME_W-1:0] outcome;
  } tile_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic                evicted;
    logic [COUNT_W-1:0]  fills;
  } lookup_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // configuration port
  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [APB_ADDR_W-1:0] paddr   = '0;
  logic [APB_DATA_W-1:0] pwdata  = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  // request and result channels
  logic                 start         = 1'b0;
  logic                 busy;
  logic [TILE_W-1:0]    tile_x        = '0;
  logic [TILE_W-1:0]    tile_y        = '0;
  logic [OUTCOME_W-1:0] fetch_outcome = OUT_PENDING;
  logic                 done;
  logic [STATUS_W-1:0]  lookup_status;
  logic [SLOT_W-1:0]    slot_index;
  logic                 evicted;
  logic [COUNT_W-1:0]   fill_count;

  lru_tile_cache_core dut (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .start         (start),
    .busy          (busy),
    .tile_x        (tile_x),
    .tile_y        (tile_y),
    .fetch_outcome (fetch_outcome),
    .done          (done),
    .lookup_status (lookup_status),
    .slot_index    (slot_index),
    .evicted       (evicted),
    .fill_count    (fill_count)
  );

  // predictor copy of the cache store and the zoom register
  logic [TILE_W-1:0]  slot_x        [CAPACITY];
  logic [TILE_W-1:0]  slot_y        [CAPACITY];
  logic [ZOOM_W-1:0]  slot_zoom     [CAPACITY];
  logic [STAMP_W-1:0] slot_stamp    [CAPACITY];
  logic               slot_has_data [CAPACITY];
  int                 slots_used    = 0;
  logic [STAMP_W-1:0] stamp_clock   = '0;
  logic [COUNT_W-1:0] data_fills    = '0;
  logic [ZOOM_W-1:0]  zoom_reg      = ZOOM_DEFAULT;

  tile_req_t pending_tiles[$];
  lookup_t   expected_lookups[$];

  logic [TILE_W-1:0] pool_x [POOL_SIZE];
  logic [TILE_W-1:0] pool_y [POOL_SIZE];

  int      errors      = 0;
  int      cycle_count = 0;
  int      gap_left    = 0;
  int      gap_now;
  bit      gaps_on     = 1'b1;
  lookup_t seen_exp;

  // tag match, lru victim search and counter update for one request
  function automatic lookup_t predict_lookup(input tile_req_t req);
    lookup_t           res;
    logic [ZOOM_W-1:0] tag_zoom;
    int                hit_slot;
    int                victim;
    tag_zoom = (zoom_reg == '0) ? ZOOM_DEFAULT : zoom_reg;
    hit_slot = -1;
    for (int i = 0; i < slots_used; i++)
      if (hit_slot < 0 && slot_zoom[i] == tag_zoom && slot_x[i] == req.x &&
          slot_y[i] == req.y)
        hit_slot = i;
    res.evicted = 1'b0;
    if (hit_slot >= 0) begin
      stamp_clock = stamp_clock + 1'b1;
      slot_stamp[hit_slot] = stamp_clock;
      res.status = slot_has_data[hit_slot] ? RES_HIT_DATA : RES_HIT_HOLE;
      res.slot   = SLOT_W'(hit_slot);
    end else if (req.outcome == OUT_PENDING) begin
      res.status = RES_PENDING;
      res.slot   = '0;
    end else begin
      if (req.outcome == OUT_DATA)
        data_fills = data_fills + 1'b1;
      if (slots_used < CAPACITY) begin
        victim = slots_used;
        slots_used++;
      end else begin
        // smallest stamp wins, lowest index on a tie
        victim = 0;
        for (int i = 1; i < CAPACITY; i++)
          if (slot_stamp[i] < slot_stamp[victim])
            victim = i;
        res.evicted = 1'b1;
      end
      stamp_clock = stamp_clock + 1'b1;
      slot_zoom[victim]     = tag_zoom;
      slot_x[victim]        = req.x;
      slot_y[victim]        = req.y;
      slot_stamp[victim]    = stamp_clock;
      slot_has_data[victim] = (req.outcome == OUT_DATA);
      res.status = (req.outcome == OUT_DATA) ? RES_FILL_DATA : RES_FILL_HOLE;
      res.slot   = SLOT_W'(victim);
    end
    res.fills = data_fills;
    return res;
  endfunction

  // idle cycles after an item: mostly none or short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 50)
      return 0;
    if (r < 90)
      return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // a request, mostly from the shared tile pool so hits and evictions occur
  function automatic tile_req_t random_request(input int pool_len);
    tile_req_t req;
    int        idx;
    int        r;
    if ($urandom_range(0, 99) < 75) begin
      idx   = $urandom_range(0, pool_len - 1);
      req.x = pool_x[idx];
      req.y = pool_y[idx];
    end else begin
      req.x = TILE_W'($urandom);
      req.y = TILE_W'($urandom);
    end
    r = $urandom_range(0, 99);
    if (r < 25)
      req.outcome = OUT_PENDING;
    else if (r < 65)
      req.outcome = OUT_DATA;
    else if (r < 90)
      req.outcome = OUT_FAILED;
    else
      req.outcome = 2'd3;
    return req;
  endfunction

  function automatic tile_req_t make_req(input logic [TILE_W-1:0] x,
                                         input logic [TILE_W-1:0] y,
                                         input logic [OUTCOME_W-1:0] outcome);
    tile_req_t req;
    req.x       = x;
    req.y       = y;
    req.outcome = outcome;
    return req;
  endfunction

  // zoom register write: setup cycle then access cycle
  task automatic write_zoom(input logic [ZOOM_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'(4 * REG_ZOOM);
    pwdata  <= APB_DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    zoom_reg = value;
  endtask

  // block until every queued item is accepted and every result has come
  task automatic wait_drained();
    do @(posedge clk);
    while (pending_tiles.size() != 0 || expected_lookups.size() != 0 || start);
    repeat (10) @(posedge clk);
  endtask

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // cycle limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // request driver: takes items from the pending queue, predicts on accept
  always @(posedge clk) begin
    if (rst) begin
      start    <= 1'b0;
      gap_left <= 0;
    end else if (!(start && busy)) begin
      if (start) begin
        expected_lookups.push_back(predict_lookup(pending_tiles[0]));
        void'(pending_tiles.pop_front());
        gap_now = pick_gap();
      end else begin
        gap_now = (gap_left > 0) ? gap_left - 1 : 0;
      end
      if (gap_now == 0 && pending_tiles.size() != 0) begin
        start         <= 1'b1;
        tile_x        <= pending_tiles[0].x;
        tile_y        <= pending_tiles[0].y;
        fetch_outcome <= pending_tiles[0].outcome;
        gap_left      <= 0;
      end else begin
        start    <= 1'b0;
        gap_left <= gap_now;
      end
    end
  end

  // result monitor: compare each strobe against the oldest expectation
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_lookups.size() == 0) begin
        $display("%0t: unexpected result status %0d slot %0d", $time, lookup_status,
                 slot_index);
        errors++;
      end else begin
        seen_exp = expected_lookups.pop_front();
        if (lookup_status !== seen_exp.status) begin
          $display("%0t: lookup_status expected %0d got %0d", $time, seen_exp.status,
                   lookup_status);
          errors++;
        end
        if (slot_index !== seen_exp.slot) begin
          $display("%0t: slot_index expected %0d got %0d", $time, seen_exp.slot,
                   slot_index);
          errors++;
        end
        if (evicted !== seen_exp.evicted) begin
          $display("%0t: evicted expected %0d got %0d", $time, seen_exp.evicted,
                   evicted);
          errors++;
        end
        if (fill_count !== seen_exp.fills) begin
          $display("%0t: fill_count expected %0d got %0d", $time, seen_exp.fills,
                   fill_count);
          errors++;
        end
      end
    end
  end

  // stimulus: directed items at reset zoom, then random phases over zoom settings
  initial begin
    logic [ZOOM_W-1:0] zoom_plan [8];
    int                pool_len;
    for (int i = 0; i < CAPACITY; i++) begin
      slot_x[i]        = '0;
      slot_y[i]        = '0;
      slot_zoom[i]     = '0;
      slot_stamp[i]    = '0;
      slot_has_data[i] = 1'b0;
    end
    // pairs share a column so partial tag matches occur
    for (int i = 0; i < POOL_SIZE; i++) begin
      pool_x[i] = (i % 2 == 1) ? pool_x[i - 1] : TILE_W'($urandom);
      pool_y[i] = TILE_W'($urandom);
    end
    zoom_plan = '{5'd24, 5'd1, 5'd0, 5'd31, 5'd11, 5'd21, 5'd10, ZOOM_W'($urandom)};

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, hits on data and holes, pending miss, outcome three
    pending_tiles.push_back(make_req('0, '0, OUT_DATA));
    pending_tiles.push_back(make_req('0, '0, OUT_PENDING));
    pending_tiles.push_back(make_req('1, '1, OUT_FAILED));
    pending_tiles.push_back(make_req('1, '1, OUT_DATA));
    pending_tiles.push_back(make_req(24'd1, 24'd2, OUT_PENDING));
    pending_tiles.push_back(make_req(24'd3, 24'd4, 2'd3));
    pending_tiles.push_back(make_req(24'd3, 24'd4, OUT_DATA));
    pending_tiles.push_back(make_req('1, '0, OUT_DATA));
    pending_tiles.push_back(make_req('0, '1, OUT_DATA));
    // fill the store, then refresh one entry and force evictions
    for (int i = 0; i < 11; i++)
      pending_tiles.push_back(make_req(TILE_W'(i + 16), TILE_W'(i), OUT_DATA));
    pending_tiles.push_back(make_req('0, '0, OUT_PENDING));
    pending_tiles.push_back(make_req(24'd5, 24'd5, OUT_DATA));
    pending_tiles.push_back(make_req(24'd6, 24'd6, OUT_FAILED));
    pending_tiles.push_back(make_req('1, '1, OUT_PENDING));
    wait_drained();

    // random phases, each behind a zoom write and a full drain
    for (int p = 0; p < 8; p++) begin
      write_zoom(zoom_plan[p]);
      gaps_on  = (p % 3 != 1);
      pool_len = $urandom_range(8, POOL_SIZE);
      for (int n = 0; n < PHASE_ITEMS; n++)
        pending_tiles.push_back(random_request(pool_len));
      wait_drained();
    end

    if (errors == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end

endmodule

`default_nettype wire
